FILE: src/gbzc_pkg.sv
// ----------------------------------------------------------------------------
// gbzc_pkg
// Shared types and constants of the grid bilinear z compensation unit.
// ----------------------------------------------------------------------------
package gbzc_pkg;

    // command codes on the input item
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_COMP  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_SPAN_X   = 3'd2;
    localparam logic [2:0] REG_SPAN_Y   = 3'd3;
    localparam logic [2:0] REG_COLS     = 3'd4;
    localparam logic [2:0] REG_ROWS     = 3'd5;
    localparam logic [2:0] REG_LIMIT    = 3'd6;
    localparam logic [2:0] REG_FADE     = 3'd7;

    // not-set marker of a grid cell
    localparam logic signed [23:0] NOT_SET = 24'sh800000;
    localparam logic [16:0]        ONE_Q16 = 17'h10000;

    // divider sizes: 42 bit numerator, 21 bit divisor and quotient
    localparam int DIV_NW = 42;
    localparam int DIV_DW = 21;
    localparam int DIV_QW = 21;

    // operation decided by the front end
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_WRITE,
        OP_COMP,
        OP_NOP
    } t_op;

    // one queued item
    typedef struct packed {
        t_op                op;
        logic [3:0]         col;
        logic [3:0]         row;
        logic signed [23:0] height;
        logic signed [20:0] tx;
        logic signed [20:0] ty;
        logic signed [20:0] tz;
        logic               inv;
    } t_item;

    // configuration seen by the back end, grid sides already clamped
    typedef struct packed {
        logic signed [20:0] origin_x;
        logic signed [20:0] origin_y;
        logic signed [20:0] span_x;
        logic signed [20:0] span_y;
        logic [4:0]         cols;
        logic [4:0]         rows;
        logic [19:0]        limit;
        logic [19:0]        fade;
    } t_cfg;

endpackage

FILE: src/gbzc_front.sv
// ----------------------------------------------------------------------------
// gbzc_front
// Classifies incoming items and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gbzc_front import gbzc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [1:0]         i_cmd,
    input  logic [3:0]         i_cell_col,
    input  logic [3:0]         i_cell_row,
    input  logic signed [23:0] i_cell_height,
    input  logic signed [20:0] i_target_x,
    input  logic signed [20:0] i_target_y,
    input  logic signed [20:0] i_target_z,
    input  logic               i_inverse,
    input  logic [4:0]         i_cols,
    input  logic [4:0]         i_rows,
    input  logic               i_pop,
    output t_item              o_head,
    output logic               o_head_valid,
    output logic               o_full
);

    t_item      n_item;
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // classify the command; writes outside the used grid do nothing
    always_comb begin
        n_item.col    = i_cell_col;
        n_item.row    = i_cell_row;
        n_item.height = i_cell_height;
        n_item.tx     = i_target_x;
        n_item.ty     = i_target_y;
        n_item.tz     = i_target_z;
        n_item.inv    = i_inverse;
        case (i_cmd)
            CMD_CLEAR: n_item.op = OP_CLEAR;
            CMD_WRITE: begin
                if (({1'b0, i_cell_col} < i_cols) && ({1'b0, i_cell_row} < i_rows))
                    n_item.op = OP_WRITE;
                else
                    n_item.op = OP_NOP;
            end
            CMD_COMP:  n_item.op = OP_COMP;
            default:   n_item.op = OP_NOP;
        endcase
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push)
                r_wp <= ~r_wp;
            if (i_pop)
                r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push)
            r_q[r_wp] <= n_item;
    end

    assign o_head       = r_q[r_rp];
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_full       = (r_cnt == 2'd2);

endmodule

FILE: src/gbzc_div.sv
// ----------------------------------------------------------------------------
// gbzc_div
// Restoring divider, one quotient bit per cycle; the quotient must fit
// in DIV_QW bits.
// ----------------------------------------------------------------------------
module gbzc_div import gbzc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_done,
    output logic [DIV_QW-1:0] o_quo
);

    logic [DIV_DW-1:0] r_rem;
    logic [DIV_QW-1:0] r_low;
    logic [DIV_DW-1:0] r_den;
    logic [4:0]        r_cnt;
    logic              r_run;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic              ge;

    // one trial subtraction
    assign trial = {r_rem, r_low[DIV_QW-1]};
    assign ge    = (trial >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && (r_cnt == 5'd1);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'(DIV_QW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1)
                    r_run <= 1'b0;
            end
        end
    end

    // datapath: low bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DIV_NW-1:DIV_QW];
            r_low <= i_num[DIV_QW-1:0];
            r_den <= i_den;
        end else if (r_run) begin
            r_rem <= ge ? DIV_DW'(trial - {1'b0, r_den}) : DIV_DW'(trial);
            r_low <= {r_low[DIV_QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_low;

endmodule

FILE: src/gbzc_back.sv
// ----------------------------------------------------------------------------
// gbzc_back
// Carries out queued items: grid clear and write, and the compensation
// sequence of fade division, axis divisions and four-cell interpolation.
// ----------------------------------------------------------------------------
module gbzc_back import gbzc_pkg::*; #(
    parameter int MAX_SIDE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_item              i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    output logic               o_init,
    output logic               o_valid,
    output logic signed [25:0] o_z_out,
    output logic               o_applied
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLEAR, S_FADE, S_WAIT_F, S_AXIS_X, S_WAIT_X,
        S_AXIS_Y, S_WAIT_Y, S_READ, S_MUL, S_ACC, S_ROUND, S_SCALE, S_FIN, S_DONE
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr;
    t_item              r_item;
    logic [16:0]        r_scale;
    logic [4:0]         r_cx;
    logic [4:0]         r_cy;
    logic [16:0]        r_rx;
    logic [16:0]        r_ry;
    logic [1:0]         r_k;
    logic [33:0]        r_w;
    logic signed [58:0] r_prod;
    logic signed [58:0] r_acc;
    logic signed [40:0] r_off16;
    logic signed [58:0] r_sprod;
    logic signed [25:0] r_z;
    logic               r_app;
    logic               r_valid;
    logic signed [23:0] r_mem [CELLS];
    logic signed [23:0] r_rdata;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [23:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [11:0]        widx;
    logic [11:0]        ridx;

    logic               damp;
    logic signed [21:0] tz_w;
    logic signed [21:0] lim_w;
    logic signed [21:0] fs_w;
    logic [20:0]        fdiff;

    logic               sel_y;
    logic signed [20:0] a_org;
    logic signed [20:0] a_span;
    logic signed [20:0] a_t;
    logic [4:0]         a_n;
    logic signed [21:0] a_end;
    logic signed [21:0] a_lo;
    logic signed [21:0] a_hi;
    logic signed [21:0] a_tc;
    logic signed [22:0] a_d;
    logic [20:0]        a_ad;
    logic [20:0]        a_den;
    logic [25:0]        a_scaled;

    logic               div_start;
    logic [DIV_NW-1:0]  div_num;
    logic [DIV_DW-1:0]  div_den;
    logic               div_done;
    logic [DIV_QW-1:0]  div_quo;
    logic [4:0]         q_n;
    logic [4:0]         q_cell;
    logic [16:0]        q_ratio;

    logic [16:0]        w_a;
    logic [16:0]        w_b;
    logic signed [58:0] rnd_sum;
    logic signed [58:0] scl_sum;
    logic signed [25:0] delta;

    // fade window
    assign tz_w  = 22'(r_item.tz);
    assign lim_w = $signed({2'b00, i_cfg.limit});
    assign fs_w  = $signed({2'b00, i_cfg.fade});
    assign damp  = (i_cfg.fade > 20'd1) && (i_cfg.limit > i_cfg.fade)
                   && ((i_cfg.limit - i_cfg.fade) > 20'd1);
    assign fdiff = 21'(tz_w - fs_w);

    // axis operand selection and clamping to the grid rectangle
    always_comb begin
        sel_y    = (r_state == S_AXIS_Y);
        a_org    = sel_y ? i_cfg.origin_y : i_cfg.origin_x;
        a_span   = sel_y ? i_cfg.span_y : i_cfg.span_x;
        a_t      = sel_y ? r_item.ty : r_item.tx;
        a_n      = sel_y ? i_cfg.rows : i_cfg.cols;
        a_end    = 22'(a_org) + 22'(a_span);
        a_lo     = a_span[20] ? a_end : 22'(a_org);
        a_hi     = a_span[20] ? 22'(a_org) : a_end;
        a_tc     = 22'(a_t);
        if (a_tc < a_lo)
            a_tc = a_lo;
        if (a_tc > a_hi)
            a_tc = a_hi;
        a_d      = 23'(a_tc) - 23'(a_org);
        a_ad     = a_d[22] ? 21'(-a_d) : 21'(a_d);
        a_den    = a_span[20] ? 21'(-a_span) : 21'(a_span);
        a_scaled = 26'(a_ad * (a_n - 5'd1));
    end

    // shared divider operands; the fade division only runs inside the fade band
    always_comb begin
        div_start = 1'b0;
        div_num   = {5'd0, fdiff, 16'd0};
        div_den   = {1'b0, i_cfg.limit - i_cfg.fade};
        case (r_state)
            S_FADE: div_start = damp && (tz_w <= lim_w) && (tz_w >= fs_w);
            S_AXIS_X, S_AXIS_Y: begin
                div_start = (a_span != 21'sd0);
                div_num   = {a_scaled, 16'd0};
                div_den   = a_den;
            end
            default: ;
        endcase
    end

    gbzc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // grid position to cell index and ratio, index limited to n - 2
    always_comb begin
        q_n    = (r_state == S_WAIT_Y) ? i_cfg.rows : i_cfg.cols;
        q_cell = div_quo[20:16];
        if (q_cell > q_n - 5'd2)
            q_cell = q_n - 5'd2;
        q_ratio = 17'(div_quo - {q_cell, 16'd0});
    end

    // grid memory ports
    always_comb begin
        widx      = 12'(i_head.col) + 12'(i_head.row * i_cfg.cols);
        ridx      = 12'(r_cx + {4'd0, r_k[1]}) + 12'((r_cy + {4'd0, r_k[0]}) * i_cfg.cols);
        mem_raddr = AW'(ridx);
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = NOT_SET;
        if ((r_state == S_INIT) || (r_state == S_CLEAR)) begin
            mem_we = 1'b1;
        end else if ((r_state == S_IDLE) && i_head_valid && (i_head.op == OP_WRITE)) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(widx);
            mem_wdata = i_head.height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    // weights and rounding
    assign w_a     = r_k[1] ? r_rx : ONE_Q16 - r_rx;
    assign w_b     = r_k[0] ? r_ry : ONE_Q16 - r_ry;
    assign rnd_sum = r_acc + 59'sd32768;
    assign scl_sum = r_sprod + 59'sd2147483648;
    assign delta   = 26'(scl_sum >>> 32);

    assign o_pop  = (r_state == S_IDLE) && i_head_valid;
    assign o_init = (r_state == S_INIT);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_INIT, S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CELLS - 1))
                        r_state <= (r_state == S_INIT) ? S_IDLE : S_DONE;
                end
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_item  <= i_head;
                        r_z     <= '0;
                        r_app   <= 1'b0;
                        r_scale <= ONE_Q16;
                        r_clr   <= '0;
                        case (i_head.op)
                            OP_CLEAR: r_state <= S_CLEAR;
                            OP_COMP:  r_state <= S_FADE;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_FADE: begin
                    // fade check runs on the latched item
                    if (damp && (tz_w > lim_w)) begin
                        r_z     <= 26'(r_item.tz);
                        r_state <= S_DONE;
                    end else if (damp && (tz_w >= fs_w)) begin
                        r_state <= S_WAIT_F;
                    end else begin
                        r_state <= S_AXIS_X;
                    end
                end
                S_WAIT_F: begin
                    if (div_done) begin
                        r_scale <= ONE_Q16 - div_quo[16:0];
                        r_state <= S_AXIS_X;
                    end
                end
                S_AXIS_X: begin
                    r_cx    <= '0;
                    r_rx    <= '0;
                    r_state <= (a_span != 21'sd0) ? S_WAIT_X : S_AXIS_Y;
                end
                S_WAIT_X: begin
                    if (div_done) begin
                        r_cx    <= q_cell;
                        r_rx    <= q_ratio;
                        r_state <= S_AXIS_Y;
                    end
                end
                S_AXIS_Y: begin
                    r_cy    <= '0;
                    r_ry    <= '0;
                    r_k     <= 2'd0;
                    r_acc   <= '0;
                    r_state <= (a_span != 21'sd0) ? S_WAIT_Y : S_READ;
                end
                S_WAIT_Y: begin
                    if (div_done) begin
                        r_cy    <= q_cell;
                        r_ry    <= q_ratio;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_w     <= w_a * w_b;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= $signed({1'b0, r_w}) * r_rdata;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc + r_prod;
                    r_k     <= r_k + 2'd1;
                    r_state <= (r_k == 2'd3) ? S_ROUND : S_READ;
                end
                S_ROUND: begin
                    r_off16 <= 41'(rnd_sum >>> 16);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_sprod <= r_off16 * $signed({1'b0, r_scale});
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_z     <= r_item.inv ? 26'(r_item.tz) - delta : 26'(r_item.tz) + delta;
                    r_app   <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid   = r_valid;
    assign o_z_out   = r_z;
    assign o_applied = r_app;

    // one result strobe per item, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for two cycles");

    // nothing leaves the queue during the power-up clear
    a_no_pop_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_pop)
        else $error("item taken during grid clear");

    // divider only finishes while the sequencer waits on it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == S_WAIT_F) || (r_state == S_WAIT_X)
                      || (r_state == S_WAIT_Y)))
        else $error("divider result not expected");

endmodule

FILE: src/grid_bilinear_z_compensation_unit.sv
// ----------------------------------------------------------------------------
// grid_bilinear_z_compensation_unit
// Bed height grid with bilinear Z compensation of move targets.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item gives one
// result on o_z_out/o_applied, shown for a single cycle with o_valid, which
// the receiver cannot stall. A compensation runs up to three 21-step
// divisions (fade factor, X and Y grid position) on one shared bit-per-cycle
// divider, then the four cell reads and multiplies; a zero span skips the
// division of its axis, and the fade division runs only for a target in the
// fade band. A target above the fade limit, with fading active, returns its Z
// uncompensated. A clear sweeps all MAX_SIDE*MAX_SIDE cells, one per cycle;
// the same sweep runs after reset with busy held high. A two-item queue lets
// the next item be taken while one is being worked on. Configuration writes
// are taken at any time but must only happen while the unit is idle.
// ----------------------------------------------------------------------------
module grid_bilinear_z_compensation_unit import gbzc_pkg::*; #(
    parameter int MAX_SIDE = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [20:0]        i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [3:0]         i_cell_col,
    input  logic [3:0]         i_cell_row,
    input  logic signed [23:0] i_cell_height,
    input  logic signed [20:0] i_target_x,
    input  logic signed [20:0] i_target_y,
    input  logic signed [20:0] i_target_z,
    input  logic               i_inverse,
    output logic               o_valid,
    output logic signed [25:0] o_z_out,
    output logic               o_applied
);

    localparam logic [6:0] SIDE = 7'(MAX_SIDE);

    logic signed [20:0] r_origin_x;
    logic signed [20:0] r_origin_y;
    logic signed [20:0] r_span_x;
    logic signed [20:0] r_span_y;
    logic [4:0]         r_cols;
    logic [4:0]         r_rows;
    logic [19:0]        r_limit;
    logic [19:0]        r_fade;

    t_cfg  cfg;
    t_item head;
    logic  head_valid;
    logic  full;
    logic  pop;
    logic  init;
    logic  push;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= 21'sd0;
            r_origin_y <= 21'sd0;
            r_span_x   <= 21'sd100000;
            r_span_y   <= 21'sd100000;
            r_cols     <= 5'd7;
            r_rows     <= 5'd7;
            r_limit    <= 20'd0;
            r_fade     <= 20'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                REG_SPAN_X:   r_span_x   <= i_cfg_data;
                REG_SPAN_Y:   r_span_y   <= i_cfg_data;
                REG_COLS:     r_cols     <= i_cfg_data[4:0];
                REG_ROWS:     r_rows     <= i_cfg_data[4:0];
                REG_LIMIT:    r_limit    <= i_cfg_data[19:0];
                REG_FADE:     r_fade     <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // grid sides clamped to 2..MAX_SIDE
    always_comb begin
        cfg.origin_x = r_origin_x;
        cfg.origin_y = r_origin_y;
        cfg.span_x   = r_span_x;
        cfg.span_y   = r_span_y;
        cfg.limit    = r_limit;
        cfg.fade     = r_fade;
        if (r_cols < 5'd2)
            cfg.cols = 5'd2;
        else if ({2'b00, r_cols} > SIDE)
            cfg.cols = 5'(MAX_SIDE);
        else
            cfg.cols = r_cols;
        if (r_rows < 5'd2)
            cfg.rows = 5'd2;
        else if ({2'b00, r_rows} > SIDE)
            cfg.rows = 5'(MAX_SIDE);
        else
            cfg.rows = r_rows;
    end

    // handshake
    assign busy = full || init;
    assign push = start && !busy;

    gbzc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_cmd         (i_cmd),
        .i_cell_col    (i_cell_col),
        .i_cell_row    (i_cell_row),
        .i_cell_height (i_cell_height),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_target_z    (i_target_z),
        .i_inverse     (i_inverse),
        .i_cols        (cfg.cols),
        .i_rows        (cfg.rows),
        .i_pop         (pop),
        .o_head        (head),
        .o_head_valid  (head_valid),
        .o_full        (full)
    );

    gbzc_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_init       (init),
        .o_valid      (o_valid),
        .o_z_out      (o_z_out),
        .o_applied    (o_applied)
    );

endmodule
